/* rtl/ltd_pkg.sv */
package ltd_pkg;

  localparam int SLOTS_DEF       = 16;
  localparam int TICKET_BITS_DEF = 10;

  localparam int CMD_W       = 2;
  localparam int SLOT_W      = 4;
  localparam int TICKET_W    = 10;
  localparam int RAND_W      = 16;
  localparam int TOTAL_W     = 14;
  localparam int BC_W        = $clog2(RAND_W + 1);
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 40;

  localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd1;
  localparam logic [CMD_W-1:0] CMD_DRAW  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_NOP   = 2'd3;

  typedef struct packed {
    logic accept;
    logic start;
    logic step;
    logic scan;
    logic mod_start;
    logic mod_step;
    logic load_out;
  } ltd_cmd_t;

  typedef struct packed {
    logic pass_done;
    logic mod_done;
  } ltd_sts_t;

endpackage

/* rtl/lottery_ticket_draw.sv */
// Lottery scheduler over a ring of task slots.
// Requests enter on the in_ channel: in_tuser carries the command (write a slot,
// clear all served marks, draw, or no operation) and in_tdata the slot fields
// and the random value. Every request yields exactly one result on the out_
// channel, with the winner and draw figures in out_tdata and the not-found flag
// in out_tuser.
// A write, clear or no-op request goes straight to the done state on acceptance.
// A draw makes one pass over the ticket memory to total the eligible tickets,
// runs a 16-step remainder unit, then makes a second circular pass from the
// current position that stops at the winner.
// The single read port of the ticket memory sets the length of both passes.
// One request is worked on at a time; the next one is taken while the previous
// result waits in the output register.
// If the receiver stalls, the finished result holds in the output register and
// a following result waits inside the block until that register is taken.
// Reset clears all slot flags, the served marks and the current position.
module lottery_ticket_draw #(
  parameter int SLOTS       = ltd_pkg::SLOTS_DEF,
  parameter int TICKET_BITS = ltd_pkg::TICKET_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // slot, ticket_count, uses_lottery, occupied, random_value
  input  logic [ltd_pkg::IN_TDATA_W-1:0]     in_tdata,
  // command
  input  logic [ltd_pkg::CMD_W-1:0]          in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // winner_slot, found, ticket_total, winning_ticket, zero fill
  output logic [ltd_pkg::OUT_TDATA_W-1:0]    out_tdata,
  // status
  output logic                               out_tuser
);

  ltd_pkg::ltd_cmd_t cmd;
  ltd_pkg::ltd_sts_t sts;

  logic [ltd_pkg::SLOT_W-1:0]  winner_slot;
  logic                        found;
  logic [ltd_pkg::TOTAL_W-1:0] ticket_total;
  logic [ltd_pkg::TOTAL_W-1:0] winning_ticket;
  logic                        status;

  ltd_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .is_draw    (in_tuser == ltd_pkg::CMD_DRAW),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid)
  );

  ltd_dp #(
    .SLOTS       (SLOTS),
    .TICKET_BITS (TICKET_BITS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .command        (in_tuser),
    .slot           (in_tdata[3:0]),
    .ticket_count   (in_tdata[13:4]),
    .uses_lottery   (in_tdata[14]),
    .occupied       (in_tdata[15]),
    .random_value   (in_tdata[31:16]),
    .winner_slot    (winner_slot),
    .found          (found),
    .ticket_total   (ticket_total),
    .winning_ticket (winning_ticket),
    .status         (status)
  );

  assign out_tdata = {7'd0, winning_ticket, ticket_total, found, winner_slot};
  assign out_tuser = status;

endmodule

/* rtl/ltd_dp.sv */
module ltd_dp #(
  parameter int SLOTS       = ltd_pkg::SLOTS_DEF,
  parameter int TICKET_BITS = ltd_pkg::TICKET_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  ltd_pkg::ltd_cmd_t              cmd,
  output ltd_pkg::ltd_sts_t              sts,
  input  logic [ltd_pkg::CMD_W-1:0]      command,
  input  logic [ltd_pkg::SLOT_W-1:0]     slot,
  input  logic [ltd_pkg::TICKET_W-1:0]   ticket_count,
  input  logic                           uses_lottery,
  input  logic                           occupied,
  input  logic [ltd_pkg::RAND_W-1:0]     random_value,
  output logic [ltd_pkg::SLOT_W-1:0]     winner_slot,
  output logic                           found,
  output logic [ltd_pkg::TOTAL_W-1:0]    ticket_total,
  output logic [ltd_pkg::TOTAL_W-1:0]    winning_ticket,
  output logic                           status
);

  localparam int IDX_W = $clog2(SLOTS);
  localparam int CNT_W = $clog2(SLOTS + 1);
  localparam int SUM_W = TICKET_BITS + IDX_W;
  localparam int CMP_W = (SUM_W > ltd_pkg::RAND_W) ? SUM_W : ltd_pkg::RAND_W;
  localparam int SW    = (IDX_W > ltd_pkg::SLOT_W) ? IDX_W : ltd_pkg::SLOT_W;
  localparam int TW    = (TICKET_BITS > ltd_pkg::TICKET_W) ? TICKET_BITS : ltd_pkg::TICKET_W;

  logic [TICKET_BITS-1:0] mem [SLOTS];
  logic [TICKET_BITS-1:0] rdata_r;

  logic [SLOTS-1:0] valid_r;
  logic [SLOTS-1:0] lot_r;
  logic [SLOTS-1:0] recent_r;
  logic [SLOTS-1:0] elig;

  logic [IDX_W-1:0]          pos_r;
  logic [IDX_W-1:0]          idx_r;
  logic [IDX_W-1:0]          idx_inc;
  logic [IDX_W-1:0]          di_r;
  logic                      dv_r;
  logic [CNT_W-1:0]          iss_r;
  logic [SUM_W-1:0]          acc_r;
  logic [SUM_W-1:0]          total_r;
  logic [CMP_W-1:0]          rem_r;
  logic [ltd_pkg::RAND_W-1:0] rnd_r;
  logic [ltd_pkg::BC_W-1:0]  bcnt_r;
  logic                      found_r;
  logic                      draw_r;

  logic [ltd_pkg::SLOT_W-1:0]  winner_r;
  logic                        found_out_r;
  logic [ltd_pkg::TOTAL_W-1:0] total_out_r;
  logic [ltd_pkg::TOTAL_W-1:0] win_out_r;
  logic                        status_r;

  logic [SW-1:0]          slot_ext;
  logic [IDX_W-1:0]       wr_addr;
  logic                   wr_ok;
  logic [TW-1:0]          tk_ext;
  logic [TICKET_BITS-1:0] wr_tk;
  logic                   is_wr;
  logic                   is_clr;
  logic                   issue;
  logic                   take;
  logic                   hit;
  logic [SUM_W:0]         acc_add;
  logic [CMP_W:0]         trial;
  logic [CMP_W:0]         tot_ext;
  logic [CMP_W:0]         diff;
  logic                   ge;
  logic [SW-1:0]          pos_ext;
  logic [CMP_W-1:0]       total_ext;

  always_comb begin
    slot_ext  = SW'(slot);
    wr_addr   = slot_ext[IDX_W-1:0];
    wr_ok     = {1'b0, slot_ext} < (SW + 1)'(SLOTS);
    tk_ext    = TW'(ticket_count);
    wr_tk     = tk_ext[TICKET_BITS-1:0];
    is_wr     = cmd.accept && (command == ltd_pkg::CMD_WRITE);
    is_clr    = cmd.accept && (command == ltd_pkg::CMD_CLEAR);
    elig      = valid_r & lot_r & ~recent_r;
    idx_inc   = (idx_r == IDX_W'(SLOTS - 1)) ? '0 : idx_r + 1'b1;
    issue     = cmd.step && (iss_r != CNT_W'(SLOTS)) && !found_r;
    take      = cmd.step && dv_r && elig[di_r] && !found_r;
    acc_add   = {1'b0, acc_r} + (SUM_W + 1)'(rdata_r);
    hit       = cmd.scan && ((CMP_W + 1)'(rem_r) < (CMP_W + 1)'(acc_add));
    trial     = {rem_r, rnd_r[ltd_pkg::RAND_W-1]};
    tot_ext   = (CMP_W + 1)'(total_r);
    ge        = trial >= tot_ext;
    diff      = trial - tot_ext;
    pos_ext   = SW'(pos_r);
    total_ext = CMP_W'(total_r);
  end

  assign sts.pass_done = found_r || ((iss_r == CNT_W'(SLOTS)) && !dv_r);
  assign sts.mod_done  = bcnt_r == ltd_pkg::BC_W'(ltd_pkg::RAND_W);

  always_ff @(posedge clk) begin
    if (is_wr && wr_ok) begin
      mem[wr_addr] <= wr_tk;
    end
    rdata_r <= mem[idx_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      lot_r    <= '0;
      recent_r <= '0;
      pos_r    <= '0;
      dv_r     <= 1'b0;
      found_r  <= 1'b0;
      draw_r   <= 1'b0;
    end else begin
      if (is_wr && wr_ok) begin
        valid_r[wr_addr] <= occupied;
        lot_r[wr_addr]   <= uses_lottery;
      end
      if (is_clr) begin
        recent_r <= '0;
      end
      if (cmd.accept) begin
        draw_r <= command == ltd_pkg::CMD_DRAW;
      end
      if (cmd.start) begin
        dv_r    <= 1'b0;
        found_r <= 1'b0;
      end else if (cmd.step) begin
        dv_r <= issue;
        if (take && hit) begin
          found_r        <= 1'b1;
          pos_r          <= di_r;
          recent_r[di_r] <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      idx_r <= pos_r;
      iss_r <= '0;
      acc_r <= '0;
    end else if (cmd.step) begin
      if (issue) begin
        di_r  <= idx_r;
        idx_r <= idx_inc;
        iss_r <= iss_r + 1'b1;
      end
      if (take && !hit) begin
        acc_r <= acc_add[SUM_W-1:0];
      end
    end
    if (cmd.accept) begin
      rnd_r <= random_value;
    end
    if (cmd.mod_start) begin
      total_r <= (acc_r == '0) ? SUM_W'(1) : acc_r;
      rem_r   <= '0;
      bcnt_r  <= '0;
    end else if (cmd.mod_step) begin
      rnd_r  <= rnd_r << 1;
      rem_r  <= ge ? diff[CMP_W-1:0] : trial[CMP_W-1:0];
      bcnt_r <= bcnt_r + 1'b1;
    end
    if (cmd.load_out) begin
      winner_r    <= pos_ext[ltd_pkg::SLOT_W-1:0];
      found_out_r <= draw_r && found_r;
      total_out_r <= draw_r ? total_ext[ltd_pkg::TOTAL_W-1:0] : '0;
      win_out_r   <= draw_r ? rem_r[ltd_pkg::TOTAL_W-1:0] : '0;
      status_r    <= draw_r && !found_r;
    end
  end

  assign winner_slot    = winner_r;
  assign found          = found_out_r;
  assign ticket_total   = total_out_r;
  assign winning_ticket = win_out_r;
  assign status         = status_r;

  a_winner_marked: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(found_r) |-> recent_r[pos_r])
    else $error("winning slot was not marked as served");

  a_total_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.mod_step |-> (total_r != '0))
    else $error("remainder step with a zero divisor");

endmodule

/* rtl/ltd_ctrl.sv */
module ltd_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  input  logic              is_draw,
  input  logic              out_tready,
  input  ltd_pkg::ltd_sts_t sts,
  output ltd_pkg::ltd_cmd_t cmd,
  output logic              in_tready,
  output logic              out_tvalid
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SUM,
    S_MOD,
    S_SCAN,
    S_DONE
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   in_tready_r;
  logic   out_tvalid_r;
  logic   fire;

  assign fire = in_tvalid && in_tready_r;

  always_comb begin
    cmd           = '0;
    cmd.accept    = fire;
    cmd.scan      = state_r == S_SCAN;
    state_nxt     = state_r;
    case (state_r)
      S_IDLE: begin
        if (fire) begin
          if (is_draw) begin
            cmd.start = 1'b1;
            state_nxt = S_SUM;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      S_SUM: begin
        if (sts.pass_done) begin
          cmd.mod_start = 1'b1;
          state_nxt     = S_MOD;
        end else begin
          cmd.step = 1'b1;
        end
      end
      S_MOD: begin
        if (sts.mod_done) begin
          cmd.start = 1'b1;
          state_nxt = S_SCAN;
        end else begin
          cmd.mod_step = 1'b1;
        end
      end
      S_SCAN: begin
        if (sts.pass_done) begin
          state_nxt = S_DONE;
        end else begin
          cmd.step = 1'b1;
        end
      end
      S_DONE: begin
        if (!out_tvalid_r || out_tready) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      in_tready_r  <= 1'b1;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      in_tready_r <= state_nxt == S_IDLE;
      if (cmd.load_out) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  assign in_tready  = in_tready_r;
  assign out_tvalid = out_tvalid_r;

  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready_r == (state_r == S_IDLE))
    else $error("input ready out of step with the idle state");

  a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |=> out_tvalid_r)
    else $error("loaded result not presented");

  a_nondraw_done: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && !is_draw) |=> (state_r == S_DONE))
    else $error("non-draw request did not go straight to completion");

endmodule
